// ===== hw/rtl/line_substring_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Line substring matcher assertion macros
// Shared assertion shorthands for the matcher's checker.
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_MATCHER_DEFINES_SVH
`define LINE_SUBSTRING_MATCHER_DEFINES_SVH

// Plain property, checked at every rising edge outside reset.
`define LSM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication, checked at every rising edge outside reset.
`define LSM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Line substring matcher package
// Widths, codes, shared types and the case-folding function.
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned OP_W            = 2;
  localparam int unsigned LEN_W           = 5;
  localparam int unsigned LINE_W          = 24;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned PAT_REG_BYTES   = 16;
  localparam int unsigned PAT_IDX_W       = $clog2(PAT_REG_BYTES);
  localparam int unsigned POS_W           = 7;
  localparam int unsigned MAX_PATTERN_DEF = 16;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE = 2'd0,
    OP_EOL  = 2'd1,
    OP_SOF  = 2'd2
  } lsm_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO   = 2'd0,
    CFG_PAT_HI   = 2'd1,
    CFG_PAT_LEN  = 2'd2,
    CFG_IGN_CASE = 2'd3
  } lsm_cfg_idx_t;

  typedef logic [PAT_REG_BYTES-1:0][BYTE_W-1:0] lsm_pat_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ignore_case;
  } lsm_cmp_cfg_t;

  function automatic logic [BYTE_W-1:0] fold(input logic ic, input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] res;
    res = c;
    if (ic && c >= 8'h41 && c <= 8'h5A) begin
      res = c + 8'h20;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lsm_in_if.sv =====
// ----------------------------------------------------------------------------
// Line substring matcher input channel
// Valid/ready channel carrying one text item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsm_in_if;
  import lsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output op, output text_byte, input ready);
  modport sink (input valid, input op, input text_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lsm_out_if.sv =====
// ----------------------------------------------------------------------------
// Line substring matcher result channel
// Valid/ready channel carrying one matching line number per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsm_out_if;
  import lsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line_number;

  modport source (output valid, output line_number, input ready);
  modport sink (input valid, input line_number, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lsm_cell.sv =====
// ----------------------------------------------------------------------------
// Line substring matcher window cell
// Holds one window byte, shifts it on to its neighbor and compares the
// incoming byte with its aligned pattern byte, extending the hit chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                         clk,
  input  wire logic                         shift_en,
  input  wire logic [lsm_pkg::BYTE_W-1:0]   byte_in,
  output logic      [lsm_pkg::BYTE_W-1:0]   byte_out,
  input  wire lsm_pkg::lsm_cmp_cfg_t        cmp_cfg,
  input  wire lsm_pkg::lsm_pat_t            pattern,
  input  wire logic                         hit_in,
  output logic                              hit_out
);
  import lsm_pkg::*;

  localparam logic [POS_W-1:0] IDX_V = POS_W'(IDX);

  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W-1:0] byte_nxt;
  logic [POS_W-1:0]  len_ext;
  logic [POS_W-1:0]  pat_pos;
  logic              active;
  logic              eq;

  assign byte_nxt = shift_en ? byte_in : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;
  assign len_ext  = POS_W'(cmp_cfg.len);
  assign active   = IDX_V < len_ext;
  assign pat_pos  = len_ext - IDX_V - POS_W'(1);
  assign eq       = fold(cmp_cfg.ignore_case, byte_in) ==
                    fold(cmp_cfg.ignore_case, pattern[pat_pos[PAT_IDX_W-1:0]]);
  assign hit_out  = hit_in && (!active || eq);

endmodule

`default_nettype wire

// ===== hw/rtl/line_substring_matcher.sv =====
// ----------------------------------------------------------------------------
// Line substring matcher
// Fixed-string line search over a byte stream with optional case folding.
// ----------------------------------------------------------------------------
// Usage: text enters on in_ch, one item per transfer: a text byte, an end of
// line or a start of file. A row of window cells shifts each byte in and
// compares the newest bytes with the pattern in parallel, so items may
// follow back to back. An end-of-line item whose line held the pattern (or
// any line while the pattern is empty) yields its line number on out_ch in
// the cycle after the transfer, from an output register. Other items yield
// nothing. Throughput is one item per cycle unless out_ch stalls: while a
// result waits and out_ch.ready is low, in_ch.ready drops; it returns in the
// cycle the result is taken. The cfg port writes the pattern, its length and
// the case-folding flag; the user must write them only while the block is
// idle, which the block itself does not enforce. Reset clears the
// configuration, the byte count, the match flag and the output valid flag
// and sets the line counter to one. The window bytes are not reset because
// a compare only uses bytes of the current line.
// ----------------------------------------------------------------------------
`default_nettype none

module line_substring_matcher #(
  parameter int unsigned MAX_PATTERN = lsm_pkg::MAX_PATTERN_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lsm_in_if.sink                                 in_ch,
  lsm_out_if.source                              out_ch,
  input  wire logic                              cfg_we,
  input  wire lsm_pkg::lsm_cfg_idx_t             cfg_index,
  input  wire logic [lsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lsm_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned LEN_LIM = (MAX_PATTERN < PAT_REG_BYTES) ? MAX_PATTERN : PAT_REG_BYTES;
  localparam logic [POS_W-1:0] LEN_LIM_V = POS_W'(LEN_LIM);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_PATTERN);

  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;
  logic [LEN_W-1:0]      pat_len_r;
  logic                  ign_case_r;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic              found_r, found_nxt;
  logic [LINE_W-1:0] line_ctr_r, line_ctr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0] line_number_r, line_number_nxt;

  logic              accept;
  logic              shift_en;
  lsm_op_t           op;
  logic [POS_W-1:0]  len_ext;
  logic [POS_W-1:0]  len_eff;
  lsm_cmp_cfg_t      cmp_cfg;
  lsm_pat_t          pattern;
  logic [MAX_PATTERN:0]             hit;
  logic [MAX_PATTERN:0][BYTE_W-1:0] win;
  logic              window_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r   <= '0;
      pat_hi_r   <= '0;
      pat_len_r  <= '0;
      ign_case_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAT_LO:   pat_lo_r   <= cfg_data;
        CFG_PAT_HI:   pat_hi_r   <= cfg_data;
        CFG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_W-1:0];
        CFG_IGN_CASE: ign_case_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign len_ext         = POS_W'(pat_len_r);
  assign len_eff         = (len_ext > LEN_LIM_V) ? LEN_LIM_V : len_ext;
  assign cmp_cfg.len     = len_eff[LEN_W-1:0];
  assign cmp_cfg.ignore_case = ign_case_r;
  assign pattern         = {pat_hi_r, pat_lo_r};

  assign op       = lsm_op_t'(in_ch.op);
  assign accept   = in_ch.valid && in_ch.ready;
  assign shift_en = accept && (op == OP_BYTE);

  assign hit[0] = 1'b1;
  assign win[0] = in_ch.text_byte;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    lsm_cell #(
      .IDX(k)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .byte_in  (win[k]),
      .byte_out (win[k+1]),
      .cmp_cfg  (cmp_cfg),
      .pattern  (pattern),
      .hit_in   (hit[k]),
      .hit_out  (hit[k+1])
    );
  end

  assign window_hit = hit[MAX_PATTERN];
  assign cnt_inc    = (cnt_r < CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;

  always_comb begin
    cnt_nxt         = cnt_r;
    found_nxt       = found_r;
    line_ctr_nxt    = line_ctr_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    line_number_nxt = line_number_r;
    if (accept) begin
      unique case (op)
        OP_BYTE: begin
          cnt_nxt = cnt_inc;
          if (len_eff != '0 && POS_W'(cnt_inc) >= len_eff && window_hit) begin
            found_nxt = 1'b1;
          end
        end
        OP_EOL: begin
          if (found_r || len_eff == '0) begin
            out_valid_nxt   = 1'b1;
            line_number_nxt = line_ctr_r;
          end
          if (line_ctr_r != LINE_MAX) begin
            line_ctr_nxt = line_ctr_r + LINE_W'(1);
          end
          cnt_nxt   = '0;
          found_nxt = 1'b0;
        end
        OP_SOF: begin
          cnt_nxt      = '0;
          found_nxt    = 1'b0;
          line_ctr_nxt = LINE_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      found_r     <= 1'b0;
      line_ctr_r  <= LINE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      line_ctr_r  <= line_ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_number_r <= line_number_nxt;
  end

  assign in_ch.ready        = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.line_number = line_number_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lsm_checker.sv =====
// ----------------------------------------------------------------------------
// Line substring matcher checker
// Port-level assertions on the matcher's channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_substring_matcher_defines.svh"

module lsm_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic [lsm_pkg::OP_W-1:0]      in_op,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [lsm_pkg::LINE_W-1:0]    out_line_number
);
  import lsm_pkg::*;

  logic in_xfer;
  logic out_free;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  `LSM_ASSERT_IMP(a_out_hold, clk, rst_n, out_valid && !out_ready, ##1 out_valid, "result dropped while stalled")
  `LSM_ASSERT_IMP(a_out_stable, clk, rst_n, out_valid && !out_ready, ##1 $stable(out_line_number), "result changed while stalled")
  `LSM_ASSERT(a_out_cause, clk, rst_n, $rose(out_valid) |-> $past(in_xfer && in_op == OP_EOL), "result without an end-of-line transfer")
  `LSM_ASSERT(a_no_result, clk, rst_n, (in_xfer && in_op != OP_EOL && out_free) |=> !out_valid, "result from a non end-of-line transfer")
  `LSM_ASSERT_IMP(a_line_nonzero, clk, rst_n, out_valid, out_line_number != '0, "line number zero")

endmodule

bind line_substring_matcher lsm_checker u_lsm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_op           (in_ch.op),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_line_number (out_ch.line_number)
);

`default_nettype wire

// ===== tb/line_substring_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line substring matcher testbench
// Streams lines of text through the matcher under a series of pattern
// settings, predicts which line numbers must come out and checks every
// result in order, with random idle cycles and back-pressure on both sides.
// ----------------------------------------------------------------------------

module line_substring_matcher_tb;
  import lsm_pkg::*;

  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RX_HOLD_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS = 70;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] ch;
  } text_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  lsm_cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lsm_in_if in_ch();
  lsm_out_if out_ch();

  line_substring_matcher #(
    .MAX_PATTERN(MAX_PATTERN_DEF)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  text_item_t text_stream_q[$];
  logic [LINE_W-1:0] due_line_numbers[$];

  logic [CFG_DATA_W-1:0] pat_lo_set;
  logic [CFG_DATA_W-1:0] pat_hi_set;
  logic [LEN_W-1:0] pat_len_set;
  logic fold_set;
  logic [PAT_REG_BYTES-1:0][BYTE_W-1:0] window_bytes;
  logic [LEN_W-1:0] line_bytes;
  logic line_hit;
  logic [LINE_W-1:0] line_count;

  int unsigned items_pushed = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned cfg_writes = 0;
  int unsigned settings_loaded = 0;
  int unsigned stall_cycles = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_left = 0;
  bit rx_hold_req = 1'b0;
  bit rx_hold_ack = 1'b0;
  logic in_xfer = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] lower(input logic [BYTE_W-1:0] c);
    return (fold_set && c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

  function automatic int unsigned active_span();
    return (pat_len_set > PAT_REG_BYTES) ? PAT_REG_BYTES : pat_len_set;
  endfunction

  function automatic void clear_line();
    window_bytes = '0;
    line_bytes = '0;
    line_hit = 1'b0;
  endfunction

  // Returns 1 when the item produces a line number, which is left in num.
  function automatic bit advance_line_state(input logic [OP_W-1:0] op,
                                            input logic [BYTE_W-1:0] ch,
                                            output logic [LINE_W-1:0] num);
    int unsigned span;
    bit hit;
    bit emit;
    lsm_pat_t pat;
    span = active_span();
    pat = {pat_hi_set, pat_lo_set};
    num = '0;
    emit = 1'b0;
    case (op)
      OP_BYTE: begin
        window_bytes = {window_bytes[PAT_REG_BYTES-2:0], ch};
        if (line_bytes < PAT_REG_BYTES) line_bytes++;
        if (span > 0 && line_bytes >= span) begin
          hit = 1'b1;
          for (int i = 0; i < span; i++) begin
            if (lower(window_bytes[span-1-i]) != lower(pat[i])) hit = 1'b0;
          end
          if (hit) line_hit = 1'b1;
        end
      end
      OP_EOL: begin
        emit = line_hit || span == 0;
        num = line_count;
        if (line_count != LINE_MAX) line_count++;
        clear_line();
      end
      OP_SOF: begin
        clear_line();
        line_count = LINE_W'(1);
      end
      default: begin
      end
    endcase
    return emit;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  always @(negedge clk) begin
    text_item_t it;
    if (!in_ch.valid || in_xfer) begin
      if (text_stream_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        it = text_stream_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op <= it.op;
        in_ch.text_byte <= it.ch;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold_req != rx_hold_ack) begin
      rx_hold_ack = rx_hold_req;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    logic [LINE_W-1:0] want;
    logic [LINE_W-1:0] num;
    in_xfer <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen <= results_seen + 1;
      if (due_line_numbers.size() == 0) begin
        report_mismatch($sformatf("line_number %0d arrived with none expected",
                                  out_ch.line_number));
      end else begin
        want = due_line_numbers.pop_front();
        if (out_ch.line_number !== want) begin
          report_mismatch($sformatf("line_number got %0d, expected %0d",
                                    out_ch.line_number, want));
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      items_taken <= items_taken + 1;
      if (advance_line_state(in_ch.op, in_ch.text_byte, num)) begin
        due_line_numbers.insert(due_line_numbers.size(), num);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] ch);
    text_item_t it;
    it.op = op;
    it.ch = ch;
    text_stream_q.insert(text_stream_q.size(), it);
    items_pushed++;
  endtask

  function automatic logic [BYTE_W-1:0] text_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) begin
      case ($urandom_range(3))
        0: return "a";
        1: return "A";
        2: return "b";
        default: return "B";
      endcase
    end
    if (roll < 70) return (roll < 65) ? 8'h00 : 8'hFF;
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pattern_word();
    logic [CFG_DATA_W-1:0] w;
    for (int i = 0; i < 8; i++) begin
      w[8*i +: 8] = ($urandom_range(9) < 8) ? text_char() : BYTE_W'($urandom_range(255));
    end
    return w;
  endfunction

  task automatic push_pattern_part(input int unsigned count);
    lsm_pat_t pat;
    logic [BYTE_W-1:0] c;
    pat = {pat_hi_set, pat_lo_set};
    for (int i = 0; i < count; i++) begin
      c = pat[i];
      if (fold_set && $urandom_range(1) &&
          ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))) begin
        c ^= 8'h20;
      end
      push_item(OP_BYTE, c);
    end
  endtask

  task automatic random_line();
    int unsigned span;
    int unsigned mode;
    int unsigned roll;
    span = active_span();
    mode = $urandom_range(99);
    repeat ($urandom_range(6)) push_item(OP_BYTE, text_char());
    if (mode < 55) begin
      push_pattern_part(span);
    end else if (mode < 75) begin
      push_pattern_part($urandom_range(span));
    end
    repeat ($urandom_range(5)) push_item(OP_BYTE, text_char());
    roll = $urandom_range(99);
    if (roll < 6) begin
      push_item(OP_SOF, BYTE_W'($urandom_range(255)));
    end else begin
      if (roll < 10) push_item(OP_IGNORED, BYTE_W'($urandom_range(255)));
      push_item(OP_EOL, BYTE_W'($urandom_range(255)));
    end
  endtask

  task automatic settle();
    @(negedge clk);
    while (items_taken != items_pushed || due_line_numbers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_matcher(input logic [CFG_DATA_W-1:0] lo,
                              input logic [CFG_DATA_W-1:0] hi,
                              input logic [LEN_W-1:0] len,
                              input logic ic);
    logic [CFG_DATA_W-1:0] junk;
    settle();
    junk = {$urandom, $urandom};
    cfg_we <= 1'b1;
    cfg_index <= CFG_PAT_LO;
    cfg_data <= lo;
    pat_lo_set = lo;
    @(negedge clk);
    cfg_index <= CFG_PAT_HI;
    cfg_data <= hi;
    pat_hi_set = hi;
    @(negedge clk);
    cfg_index <= CFG_PAT_LEN;
    cfg_data <= {junk[CFG_DATA_W-1:LEN_W], len};
    pat_len_set = len;
    @(negedge clk);
    cfg_index <= CFG_IGN_CASE;
    cfg_data <= {junk[CFG_DATA_W-1:1], ic};
    fold_set = ic;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes += 4;
    settings_loaded++;
    @(posedge clk);
  endtask

  initial begin
    int unsigned phase_len[12];
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    int unsigned phase_end;
    phase_len = '{1, 0, 16, 31, 3, 2, 5, 17, 8, 0, 12, 4};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_PAT_LO;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_BYTE;
    in_ch.text_byte = '0;
    out_ch.ready = 1'b0;
    tx_idle_pct = 23;
    rx_idle_pct = 23;
    pat_lo_set = '0;
    pat_hi_set = '0;
    pat_len_set = '0;
    fold_set = 1'b0;
    clear_line();
    line_count = LINE_W'(1);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the empty pattern reports every line, empty ones too.
    push_item(OP_EOL, 8'h00);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_EOL, 8'hFF);
    push_item(OP_IGNORED, 8'hA5);
    push_item(OP_SOF, 8'h5A);
    push_item(OP_EOL, 8'h3C);

    // A line shorter than the pattern must not match against the cleared window.
    load_matcher(64'h4100, '1, 5'd2, 1'b0);
    push_item(OP_BYTE, "A");
    push_item(OP_EOL, 8'h00);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, "A");
    push_item(OP_EOL, 8'h00);

    // Case folding, a file restart in mid-line, and a match that stays
    // found across a settings change within the line.
    load_matcher(64'h4261, '0, 5'd2, 1'b1);
    push_item(OP_BYTE, "x");
    push_item(OP_BYTE, "A");
    push_item(OP_BYTE, "b");
    push_item(OP_EOL, 8'h00);
    push_item(OP_BYTE, "A");
    push_item(OP_SOF, 8'hC3);
    push_item(OP_BYTE, "b");
    push_item(OP_EOL, 8'h00);
    push_item(OP_BYTE, "A");
    push_item(OP_BYTE, "b");
    load_matcher(64'h4261, '0, 5'd5, 1'b0);
    push_item(OP_EOL, 8'h00);

    for (int p = 0; p < 12; p++) begin
      lo = (p % 3 == 2) ? {$urandom, $urandom} : pattern_word();
      hi = (p % 3 == 2) ? {$urandom, $urandom} : pattern_word();
      if (p == 5) begin
        lo = '1;
        hi = '1;
      end
      load_matcher(lo, hi, LEN_W'(phase_len[p]), 1'(p % 2));
      tx_idle_pct = (p == 4) ? 0 : 23;
      rx_idle_pct = (p == 4) ? 0 : 23;
      if (p == 1) begin
        tx_idle_pct = 0;
        rx_hold_req = ~rx_hold_req;
      end
      phase_end = items_pushed + PHASE_ITEMS;
      while (items_pushed < phase_end) random_line();
      repeat ($urandom_range(3)) push_item(OP_BYTE, text_char());
    end

    settle();
    repeat (8) @(negedge clk);
    $display("run covered %0d text items under %0d pattern settings (%0d register writes)",
             items_taken, settings_loaded, cfg_writes);
    $display("%0d matching line numbers checked, %0d mismatches", results_seen,
             mismatch_count);
    if (mismatch_count == 0 && due_line_numbers.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
